[src/hbs_pkg.sv]
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the 3x3 heightmap box smoother: field widths,
// register indexes, the reciprocal used for the divide by nine, the position
// flags fed to the window and the beat structs passed on to the mean stage.
// ----------------------------------------------------------------------------
package hbs_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 10;
   localparam int MEAN_W     = 12;
   localparam int COLSUM_W   = 10;
   localparam int SUM_W      = 12;
   localparam int X_W        = 16;
   localparam int RECIP_W    = 18;
   localparam int PROD_W     = X_W + RECIP_W;
   localparam int QLSB       = 21;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - MEAN_W - ROW_W - OUT_COL_W;

   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int GRID_W_BITS = 11;
   localparam int GRID_H_BITS = 13;
   localparam int MAX_HEIGHT  = 4096;
   localparam int RESET_GRID  = 256;
   localparam int MIN_GRID    = 2;

   // (2^21 + 1) / 9, exact floor for every x below 2^21
   localparam logic [RECIP_W-1:0] RECIP_NINE = 18'd233017;
   localparam logic [X_W-1:0]     ROUND_BIAS = 16'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic row_ge1;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic col_last;
      logic row_last;
   } pos_flags_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] column;
      logic                 last;
      logic                 done;
   } result_meta_type;

   typedef struct packed {
      logic            valid;
      logic [SUM_W-1:0] sum;
      result_meta_type meta;
   } result_beat_type;

endpackage

[src/hbs_line_buf.sv]
// ----------------------------------------------------------------------------
// hbs_line_buf
// Two line memories holding rows r-1 and r-2. Row r-1 is read and rewritten
// with the new sample at the same address (old data comes out); row r-2 is
// written later, once the window shifts, with the data read from row r-1.
// ----------------------------------------------------------------------------
module hbs_line_buf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic [hbs_pkg::SAMPLE_W-1:0]  prev_wdata,
   input  logic                          older_we,
   input  logic [$clog2(MAX_WIDTH)-1:0]  older_waddr,
   input  logic [hbs_pkg::SAMPLE_W-1:0]  older_wdata,
   output logic [hbs_pkg::SAMPLE_W-1:0]  prev_rdata,
   output logic [hbs_pkg::SAMPLE_W-1:0]  older_rdata
);

   logic [hbs_pkg::SAMPLE_W-1:0] prev_mem  [MAX_WIDTH];
   logic [hbs_pkg::SAMPLE_W-1:0] older_mem [MAX_WIDTH];
   logic [hbs_pkg::SAMPLE_W-1:0] prev_rd_ff;
   logic [hbs_pkg::SAMPLE_W-1:0] older_rd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         prev_rd_ff        <= prev_mem[rd_addr];
         prev_mem[rd_addr] <= prev_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         older_rd_ff <= older_mem[rd_addr];
      end
      if (older_we) begin
         older_mem[older_waddr] <= older_wdata;
      end
   end

   assign prev_rdata  = prev_rd_ff;
   assign older_rdata = older_rd_ff;

endmodule

[src/hbs_window.sv]
// ----------------------------------------------------------------------------
// hbs_window
// Holds the sample whose line reads are in flight, shifts the 3x3 window,
// forms the four candidate neighborhood sums and then hands the pending
// results to the mean stage one beat per cycle while it is ready.
// ----------------------------------------------------------------------------
module hbs_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            restart,
   input  logic                            load,
   input  logic [hbs_pkg::SAMPLE_W-1:0]    load_sample,
   input  logic [$clog2(MAX_WIDTH)-1:0]    load_col,
   input  logic [hbs_pkg::ROW_W-1:0]       load_row,
   input  hbs_pkg::pos_flags_type          load_flags,
   output logic                            load_ready,
   input  logic [hbs_pkg::SAMPLE_W-1:0]    prev_rdata,
   input  logic [hbs_pkg::SAMPLE_W-1:0]    older_rdata,
   output logic                            older_we,
   output logic [$clog2(MAX_WIDTH)-1:0]    older_waddr,
   output logic [hbs_pkg::SAMPLE_W-1:0]    older_wdata,
   output hbs_pkg::result_beat_type        beat,
   input  logic                            beat_ready
);

   localparam int ColW     = $clog2(MAX_WIDTH);
   localparam int SampleW  = hbs_pkg::SAMPLE_W;
   localparam int ColSumW  = hbs_pkg::COLSUM_W;
   localparam int SumW     = hbs_pkg::SUM_W;
   localparam int RowW     = hbs_pkg::ROW_W;
   localparam int OutColW  = hbs_pkg::OUT_COL_W;

   logic                    b_valid_ff;
   logic [SampleW-1:0]      b_sample_ff;
   logic [ColW-1:0]         b_col_ff;
   logic [RowW-1:0]         b_row_ff;
   hbs_pkg::pos_flags_type  b_flags_ff;

   logic [SampleW-1:0]      win_ff [9];
   logic [SampleW-1:0]      win_in [9];

   logic [3:0]              c_pend_ff;
   logic [3:0]              c_pend_in;
   logic [SumW-1:0]         c_sum_ff [4];
   logic [SumW-1:0]         c_sum_in [4];
   logic [ColW-1:0]         c_col_ff;
   logic [RowW-1:0]         c_row_ff;

   logic [SampleW-1:0]      mid;
   logic [SampleW-1:0]      top;
   logic [ColSumW-1:0]      full_sum [3];
   logic [ColSumW-1:0]      last_sum [3];
   logic [ColSumW-1:0]      full_left;
   logic [ColSumW-1:0]      last_left;
   logic [3:0]              mask;

   logic [3:0]              sel;
   logic [1:0]              sel_idx;
   logic [3:0]              remaining;
   logic                    c_valid;
   logic                    c_pop;
   logic                    c_last;
   logic                    c_free;
   logic                    b_go;

   // window taps after the shift, index column*3 + tap (top, mid, bottom)
   always_comb begin
      mid = b_flags_ff.row_ge1 ? prev_rdata : b_sample_ff;
      top = b_flags_ff.row_ge2 ? older_rdata : mid;
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i + 3];
      end
      win_in[6] = top;
      win_in[7] = mid;
      win_in[8] = b_sample_ff;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         full_sum[k] = ColSumW'(win_in[3*k]) + ColSumW'(win_in[3*k+1])
                     + ColSumW'(win_in[3*k+2]);
         last_sum[k] = ColSumW'(win_in[3*k+1]) + {1'b0, win_in[3*k+2], 1'b0};
      end
      full_left   = b_flags_ff.col_ge2 ? full_sum[0] : full_sum[1];
      last_left   = b_flags_ff.col_ge2 ? last_sum[0] : last_sum[1];
      c_sum_in[0] = SumW'(full_left) + SumW'(full_sum[1]) + SumW'(full_sum[2]);
      c_sum_in[1] = SumW'(full_sum[1]) + {1'b0, full_sum[2], 1'b0};
      c_sum_in[2] = SumW'(last_left) + SumW'(last_sum[1]) + SumW'(last_sum[2]);
      c_sum_in[3] = SumW'(last_sum[1]) + {1'b0, last_sum[2], 1'b0};
      mask[0] = b_flags_ff.row_ge1 && b_flags_ff.col_ge1;
      mask[1] = b_flags_ff.row_ge1 && b_flags_ff.col_last;
      mask[2] = b_flags_ff.row_last && b_flags_ff.col_ge1;
      mask[3] = b_flags_ff.row_last && b_flags_ff.col_last;
   end

   // pick the lowest pending result
   always_comb begin
      sel = c_pend_ff & (~c_pend_ff + 4'd1);
      unique case (sel)
         4'b0001: sel_idx = 2'd0;
         4'b0010: sel_idx = 2'd1;
         4'b0100: sel_idx = 2'd2;
         4'b1000: sel_idx = 2'd3;
         default: sel_idx = 2'd0;
      endcase
      remaining  = c_pend_ff & ~sel;
      c_valid    = |c_pend_ff;
      c_pop      = c_valid && beat_ready;
      c_last     = (remaining == 4'd0);
      c_free     = !c_valid || (c_pop && c_last);
      b_go       = b_valid_ff && c_free;
      load_ready = !b_valid_ff || b_go;
      c_pend_in  = b_go ? mask : (c_pop ? remaining : c_pend_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (load_ready) begin
         b_valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_ready) begin
         b_sample_ff <= load_sample;
         b_col_ff    <= load_col;
         b_row_ff    <= load_row;
         b_flags_ff  <= load_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (b_go) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_pend_ff <= '0;
      end else begin
         c_pend_ff <= c_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         for (int k = 0; k < 4; k++) begin
            c_sum_ff[k] <= c_sum_in[k];
         end
         c_col_ff <= b_col_ff;
         c_row_ff <= b_row_ff;
      end
   end

   assign older_we    = b_go && b_flags_ff.row_ge1;
   assign older_waddr = b_col_ff;
   assign older_wdata = prev_rdata;

   always_comb begin
      beat.valid       = c_valid;
      beat.sum         = c_sum_ff[sel_idx];
      beat.meta.row    = sel_idx[1] ? c_row_ff : c_row_ff - RowW'(1);
      beat.meta.column = sel_idx[0] ? OutColW'(c_col_ff) : OutColW'(c_col_ff - ColW'(1));
      beat.meta.last   = c_last;
      beat.meta.done   = (sel_idx == 2'd3);
   end

endmodule

[src/hbs_mean.sv]
// ----------------------------------------------------------------------------
// hbs_mean
// Turns a neighborhood sum into round(16*sum/9) with one constant multiply:
// a bias stage, then the product lands in the output register that drives
// the result channel.
// ----------------------------------------------------------------------------
module hbs_mean (
   input  logic                             clock,
   input  logic                             reset,
   input  hbs_pkg::result_beat_type         beat,
   output logic                             beat_ready,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [hbs_pkg::MEAN_W-1:0]       out_mean,
   output hbs_pkg::result_meta_type         out_meta
);

   localparam int XW    = hbs_pkg::X_W;
   localparam int ProdW = hbs_pkg::PROD_W;

   logic                      d_valid_ff;
   logic [XW-1:0]             d_x_ff;
   hbs_pkg::result_meta_type  d_meta_ff;
   logic [XW-1:0]             d_x_in;

   logic                      o_valid_ff;
   logic [ProdW-1:0]          o_prod_ff;
   logic [ProdW-1:0]          o_prod_in;
   hbs_pkg::result_meta_type  o_meta_ff;
   logic                      o_can;

   assign o_can      = !o_valid_ff || out_ready;
   assign beat_ready = !d_valid_ff || o_can;
   assign d_x_in     = {beat.sum, 4'b0000} + hbs_pkg::ROUND_BIAS;
   assign o_prod_in  = ProdW'(d_x_ff) * ProdW'(hbs_pkg::RECIP_NINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (beat_ready) begin
         d_valid_ff <= beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_ready && beat.valid) begin
         d_x_ff    <= d_x_in;
         d_meta_ff <= beat.meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_can) begin
         o_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_can && d_valid_ff) begin
         o_prod_ff <= o_prod_in;
         o_meta_ff <= d_meta_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_mean  = o_prod_ff[hbs_pkg::QLSB +: hbs_pkg::MEAN_W];
   assign out_meta  = o_meta_ff;

endmodule

[src/heightmap_box_smooth_3x3.sv]
// ----------------------------------------------------------------------------
// heightmap_box_smooth_3x3
// Streaming 3x3 box filter over a row-major height grid with replicated
// edges; each result is the neighborhood mean in unsigned Q8.4.
// Path: a taken sample passes the sample, sum, bias and output registers;
// further results of the same sample follow one per cycle while the result
// channel is ready. Throughput: one sample per cycle while each sample causes
// at most one result and results are taken; the result sequencer holds the
// input while extra results go out (up to 4 in the last row and last column).
// Reset: control, counters and window clear at once; line memories are not
// cleared and need no clearing pass. A config write restarts the frame.
// ----------------------------------------------------------------------------
module heightmap_box_smooth_3x3 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: height_sample[7:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hbs_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // rsp_tdata: smoothed_height[11:0], out_row[23:12], out_column[33:24], zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hbs_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // rsp_tuser: frame_done
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [hbs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ColW          = $clog2(MAX_WIDTH);
   localparam int RowW          = hbs_pkg::ROW_W;
   localparam int ResetWidth    = (hbs_pkg::RESET_GRID > MAX_WIDTH) ? MAX_WIDTH
                                                                    : hbs_pkg::RESET_GRID;
   localparam logic [ColW-1:0] ResetLastCol = ColW'(ResetWidth - 1);
   localparam logic [RowW-1:0] ResetLastRow = RowW'(hbs_pkg::RESET_GRID - 1);

   logic [ColW-1:0]  last_col_ff;
   logic [ColW-1:0]  last_col_in;
   logic [RowW-1:0]  last_row_ff;
   logic [RowW-1:0]  last_row_in;
   logic [31:0]      width_req;
   logic [31:0]      width_eff;
   logic [31:0]      height_req;
   logic [31:0]      height_eff;
   logic             restart;

   logic [ColW-1:0]  col_ff;
   logic [ColW-1:0]  col_in;
   logic [RowW-1:0]  row_ff;
   logic [RowW-1:0]  row_in;
   logic             accept;
   hbs_pkg::pos_flags_type flags;

   logic [hbs_pkg::SAMPLE_W-1:0] prev_rdata;
   logic [hbs_pkg::SAMPLE_W-1:0] older_rdata;
   logic                         older_we;
   logic [ColW-1:0]              older_waddr;
   logic [hbs_pkg::SAMPLE_W-1:0] older_wdata;

   hbs_pkg::result_beat_type     beat;
   logic                         beat_ready;
   logic [hbs_pkg::MEAN_W-1:0]   out_mean;
   hbs_pkg::result_meta_type     out_meta;

   // register writes, clamped to the supported grid
   always_comb begin
      width_req  = 32'(csr_wdata[hbs_pkg::GRID_W_BITS-1:0]);
      height_req = 32'(csr_wdata[hbs_pkg::GRID_H_BITS-1:0]);
      if (width_req < 32'(hbs_pkg::MIN_GRID)) begin
         width_eff = 32'(hbs_pkg::MIN_GRID);
      end else if (width_req > 32'(MAX_WIDTH)) begin
         width_eff = 32'(MAX_WIDTH);
      end else begin
         width_eff = width_req;
      end
      if (height_req < 32'(hbs_pkg::MIN_GRID)) begin
         height_eff = 32'(hbs_pkg::MIN_GRID);
      end else if (height_req > 32'(hbs_pkg::MAX_HEIGHT)) begin
         height_eff = 32'(hbs_pkg::MAX_HEIGHT);
      end else begin
         height_eff = height_req;
      end
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      restart     = 1'b0;
      if (csr_we) begin
         unique case (hbs_pkg::csr_index_type'(csr_addr))
            hbs_pkg::CSR_GRID_WIDTH: begin
               last_col_in = ColW'(width_eff - 32'd1);
               restart     = 1'b1;
            end
            hbs_pkg::CSR_GRID_HEIGHT: begin
               last_row_in = RowW'(height_eff - 32'd1);
               restart     = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= ResetLastCol;
         last_row_ff <= ResetLastRow;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   // grid position of the next sample
   assign accept = req_tvalid && req_tready;

   always_comb begin
      flags.row_ge1  = (row_ff != '0);
      flags.row_ge2  = (row_ff > RowW'(1));
      flags.col_ge1  = (col_ff != '0);
      flags.col_ge2  = (col_ff > ColW'(1));
      flags.col_last = (col_ff == last_col_ff);
      flags.row_last = (row_ff == last_row_ff);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.col_last) begin
            col_in = '0;
            row_in = flags.row_last ? '0 : row_ff + RowW'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   hbs_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock       (clock),
      .rd_en       (accept),
      .rd_addr     (col_ff),
      .prev_wdata  (req_tdata[hbs_pkg::SAMPLE_W-1:0]),
      .older_we    (older_we),
      .older_waddr (older_waddr),
      .older_wdata (older_wdata),
      .prev_rdata  (prev_rdata),
      .older_rdata (older_rdata)
   );

   hbs_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .load        (req_tvalid),
      .load_sample (req_tdata[hbs_pkg::SAMPLE_W-1:0]),
      .load_col    (col_ff),
      .load_row    (row_ff),
      .load_flags  (flags),
      .load_ready  (req_tready),
      .prev_rdata  (prev_rdata),
      .older_rdata (older_rdata),
      .older_we    (older_we),
      .older_waddr (older_waddr),
      .older_wdata (older_wdata),
      .beat        (beat),
      .beat_ready  (beat_ready)
   );

   hbs_mean u_mean (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .beat_ready (beat_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_mean   (out_mean),
      .out_meta   (out_meta)
   );

   assign rsp_tdata = {{hbs_pkg::RSP_PAD_W{1'b0}}, out_meta.column, out_meta.row, out_mean};
   assign rsp_tlast = out_meta.last;
   assign rsp_tuser = out_meta.done;

endmodule

[src/hbs_checker.sv]
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the box smoother: reset state, result hold under
// backpressure, and grouping of the results caused by one sample.
// ----------------------------------------------------------------------------
module hbs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hbs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // out of reset: nothing pending, input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

   // the results of one sample come out back to back
   a_run_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a run of results");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end not at end of run");

   a_no_take_unready: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready && !rsp_tvalid) |=> !(rsp_tvalid && rsp_tuser && !rsp_tlast))
      else $error("frame end beat without last");

endmodule

bind heightmap_box_smooth_3x3 hbs_checker u_hbs_checker (.*);
